[hw/rtl/pbts_pkg.sv]
package pbts_pkg;

   localparam int NUM_LEVELS = 8;
   localparam int LVL_W      = $clog2(NUM_LEVELS);
   localparam int LVL_EXT_W  = (LVL_W > 3) ? LVL_W : 3;
   localparam int MAP_EXT_W  = (NUM_LEVELS > 8) ? NUM_LEVELS : 8;
   localparam int CNT_LIMIT  = (NUM_LEVELS < 15) ? NUM_LEVELS : 15;
   localparam int DLY_W      = 32;

   typedef logic [LVL_W-1:0] lvl_type;

   localparam lvl_type LAST_LVL = lvl_type'(NUM_LEVELS - 1);

   typedef enum logic [1:0] {
      OP_CREATE,
      OP_DELAY,
      OP_TICK,
      OP_SWITCH
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK_RD,
      ST_TICK_WR,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      logic    tick_wr;
      logic    scan;
      lvl_type idx;
   } seq_ctrl_type;

   typedef struct packed {
      logic run_valid;
      logic ready_hit;
      logic expire;
      logic sw_seen;
   } seq_stat_type;

endpackage

[hw/rtl/pbts_dly_mem.sv]
module pbts_dly_mem
   import pbts_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  lvl_type          wr_addr,
   input  logic [DLY_W-1:0] wr_data,
   input  lvl_type          rd_addr,
   output logic [DLY_W-1:0] rd_data
);

   logic [DLY_W-1:0] mem [NUM_LEVELS];
   logic [DLY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pbts_seq.sv]
module pbts_seq
   import pbts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   opcode,
   input  seq_stat_type stat,
   output seq_ctrl_type ctrl
);

   state_type  state_ff, state_in;
   lvl_type    idx_ff, idx_in;
   opcode_type op;
   logic       go;

   assign op = opcode_type'(opcode);
   assign go = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               unique case (op)
                  OP_CREATE: begin
                     state_in = ST_DONE;
                  end
                  OP_DELAY: begin
                     state_in = stat.run_valid ? ST_SCAN : ST_DONE;
                     idx_in   = LAST_LVL;
                  end
                  OP_TICK: begin
                     state_in = ST_TICK_RD;
                     idx_in   = '0;
                  end
                  OP_SWITCH: begin
                     state_in = ST_SCAN;
                     idx_in   = LAST_LVL;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_WR;
         end
         ST_TICK_WR: begin
            if (idx_ff == LAST_LVL) begin
               state_in = (stat.sw_seen || stat.expire) ? ST_SCAN : ST_DONE;
               idx_in   = LAST_LVL;
            end else begin
               state_in = ST_TICK_RD;
               idx_in   = idx_ff + lvl_type'(1);
            end
         end
         ST_SCAN: begin
            if (stat.ready_hit || (idx_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff - lvl_type'(1);
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.busy    = (state_ff != ST_IDLE);
      ctrl.done    = (state_ff == ST_DONE);
      ctrl.tick_wr = (state_ff == ST_TICK_WR);
      ctrl.scan    = (state_ff == ST_SCAN);
      ctrl.idx     = idx_ff;
   end

endmodule

[hw/rtl/priority_bitmap_task_scheduler_top.sv]
// Response path: create goes straight to the response; delay (with a task active) and switch
// scan the levels from the top down to the first ready one; tick reads and writes each slot
// through the delay memory port, then runs the level scan if any slot expired.
// busy stays high through the response cycle; the next word can be taken in the cycle after it.
// Results are single-cycle strobes; the receiver cannot stall.
// Synchronous active-high reset returns to idle and clears all state but the delay memory.
module priority_bitmap_task_scheduler_top
   import pbts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [7:0]        req_priority_req,
   input  logic [DLY_W-1:0]  req_delay_ticks,
   output logic              rsp_valid,
   output logic [2:0]        rsp_current_priority,
   output logic              rsp_task_active,
   output logic              rsp_switch_requested,
   output logic [7:0]        rsp_ready_levels,
   output logic [31:0]       rsp_ticks_elapsed,
   output logic [3:0]        rsp_tasks_created
);

   seq_ctrl_type ctrl;
   seq_stat_type stat;

   logic [NUM_LEVELS-1:0] ready_map_ff, ready_map_in;
   logic [NUM_LEVELS-1:0] present_ff, present_in;
   lvl_type               run_lvl_ff, run_lvl_in;
   logic                  run_valid_ff, run_valid_in;
   logic [31:0]           tick_ff, tick_in;
   logic [3:0]            cnt_ff, cnt_in;
   logic                  sw_ff, sw_in;

   logic                  accept;
   opcode_type            op;
   lvl_type               clamp_lvl;
   logic                  mem_we;
   lvl_type               mem_waddr;
   logic [DLY_W-1:0]      mem_wdata;
   logic [DLY_W-1:0]      mem_rdata;
   logic                  dly_zero;
   logic [DLY_W-1:0]      dly_dec;
   logic [LVL_EXT_W-1:0]  lvl_ext;
   logic [MAP_EXT_W-1:0]  map_ext;

   assign accept    = start && !ctrl.busy;
   assign op        = opcode_type'(req_opcode);
   assign clamp_lvl = ({1'b0, req_priority_req} >= 9'(NUM_LEVELS)) ? LAST_LVL
                                                                   : lvl_type'(req_priority_req);

   // shared countdown unit
   assign dly_zero = (mem_rdata == '0);
   assign dly_dec  = mem_rdata - DLY_W'(1);

   assign stat.run_valid = run_valid_ff;
   assign stat.ready_hit = ready_map_ff[ctrl.idx];
   assign stat.expire    = present_ff[ctrl.idx] && dly_zero;
   assign stat.sw_seen   = sw_ff;

   pbts_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .stat   (stat),
      .ctrl   (ctrl)
   );

   pbts_dly_mem u_dly_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (ctrl.idx),
      .rd_data (mem_rdata)
   );

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ctrl.idx;
      mem_wdata = dly_dec;
      priority if (accept && (op == OP_CREATE)) begin
         mem_we    = 1'b1;
         mem_waddr = clamp_lvl;
         mem_wdata = '0;
      end else if (accept && (op == OP_DELAY) && run_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = run_lvl_ff;
         mem_wdata = req_delay_ticks;
      end else if (ctrl.tick_wr && present_ff[ctrl.idx] && !dly_zero) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      ready_map_in = ready_map_ff;
      present_in   = present_ff;
      run_lvl_in   = run_lvl_ff;
      run_valid_in = run_valid_ff;
      tick_in      = tick_ff;
      cnt_in       = cnt_ff;
      sw_in        = sw_ff;
      priority if (accept) begin
         sw_in = 1'b0;
         unique case (op)
            OP_CREATE: begin
               if (cnt_ff < 4'(CNT_LIMIT)) begin
                  cnt_in = cnt_ff + 4'd1;
               end
               present_in[clamp_lvl]   = 1'b1;
               ready_map_in[clamp_lvl] = 1'b1;
               if (!run_valid_ff || (run_lvl_ff <= clamp_lvl)) begin
                  run_lvl_in   = clamp_lvl;
                  run_valid_in = 1'b1;
               end
            end
            OP_DELAY: begin
               if (run_valid_ff) begin
                  ready_map_in[run_lvl_ff] = 1'b0;
               end
            end
            OP_TICK: begin
               tick_in = tick_ff + 32'd1;
            end
            OP_SWITCH: begin
            end
            default: begin
            end
         endcase
      end else if (ctrl.tick_wr) begin
         if (stat.expire) begin
            ready_map_in[ctrl.idx] = 1'b1;
            sw_in                  = 1'b1;
         end
      end else if (ctrl.scan) begin
         if (stat.ready_hit) begin
            run_lvl_in   = ctrl.idx;
            run_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_map_ff <= '0;
         present_ff   <= '0;
         run_lvl_ff   <= '0;
         run_valid_ff <= 1'b0;
         tick_ff      <= '0;
         cnt_ff       <= '0;
         sw_ff        <= 1'b0;
      end else begin
         ready_map_ff <= ready_map_in;
         present_ff   <= present_in;
         run_lvl_ff   <= run_lvl_in;
         run_valid_ff <= run_valid_in;
         tick_ff      <= tick_in;
         cnt_ff       <= cnt_in;
         sw_ff        <= sw_in;
      end
   end

   assign lvl_ext = LVL_EXT_W'(run_lvl_ff);
   assign map_ext = MAP_EXT_W'(ready_map_ff);

   assign busy                 = ctrl.busy;
   assign rsp_valid            = ctrl.done;
   assign rsp_current_priority = lvl_ext[2:0];
   assign rsp_task_active      = run_valid_ff;
   assign rsp_switch_requested = sw_ff;
   assign rsp_ready_levels     = map_ext[7:0];
   assign rsp_ticks_elapsed    = tick_ff;
   assign rsp_tasks_created    = cnt_ff;

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepted word");

   a_active_sticky: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff |=> run_valid_ff)
      else $error("task_active dropped");

   a_ready_implies_active: assert property (@(posedge clock) disable iff (reset)
      (ready_map_ff != '0) |-> run_valid_ff)
      else $error("ready levels with no task selected");

   a_switch_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_switch_requested) |-> rsp_task_active)
      else $error("switch requested without an active task");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(CNT_LIMIT))
      else $error("task count above limit");
`endif

endmodule

[tb/tb_top.sv]
module tb_top;
   import pbts_pkg::*;

   typedef struct packed {
      logic [2:0]  cur_pri;
      logic        active;
      logic        sw;
      logic [7:0]  ready;
      logic [31:0] ticks;
      logic [3:0]  created;
   } status_type;

   class sched_scoreboard;
      logic [MAP_EXT_W-1:0] ready_map;
      logic [DLY_W-1:0]     sleep_left [NUM_LEVELS];
      bit                   occupied [NUM_LEVELS];
      lvl_type              run_lvl;
      bit                   run_valid;
      logic [31:0]          tick_count;
      logic [3:0]           task_count;
      status_type           status_q [$];
      int                   errors;
      int                   checked;
      int                   wakeups;
      int                   op_count [4];

      function new();
         ready_map  = '0;
         run_lvl    = '0;
         run_valid  = 0;
         tick_count = '0;
         task_count = '0;
         errors     = 0;
         checked    = 0;
         wakeups    = 0;
         foreach (sleep_left[i]) begin
            sleep_left[i] = '0;
            occupied[i]   = 0;
         end
         foreach (op_count[i]) op_count[i] = 0;
      endfunction

      function void pick_highest();
         if (ready_map == '0) return;
         for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (ready_map[i]) begin
               run_lvl   = lvl_type'(i);
               run_valid = 1;
               return;
            end
         end
      endfunction

      function void note_word(opcode_type op, logic [7:0] pri, logic [DLY_W-1:0] dly);
         lvl_type    lvl;
         bit         sw;
         status_type s;
         sw = 0;
         op_count[op]++;
         case (op)
            OP_CREATE: begin
               lvl = (pri >= NUM_LEVELS) ? LAST_LVL : lvl_type'(pri);
               if (task_count < CNT_LIMIT) task_count++;
               occupied[lvl]   = 1;
               sleep_left[lvl] = '0;
               ready_map[lvl]  = 1'b1;
               if (!run_valid || run_lvl <= lvl) begin
                  run_lvl   = lvl;
                  run_valid = 1;
               end
            end
            OP_DELAY: begin
               if (run_valid) begin
                  sleep_left[run_lvl] = dly;
                  ready_map[run_lvl]  = 1'b0;
                  pick_highest();
               end
            end
            OP_TICK: begin
               tick_count++;
               for (int i = 0; i < NUM_LEVELS; i++) begin
                  if (occupied[i]) begin
                     if (sleep_left[i] != '0) begin
                        sleep_left[i]--;
                     end else begin
                        ready_map[i] = 1'b1;
                        sw = 1;
                     end
                  end
               end
               if (sw) begin
                  wakeups++;
                  pick_highest();
               end
            end
            default: pick_highest();
         endcase
         s.cur_pri = 3'(run_lvl);
         s.active  = run_valid;
         s.sw      = sw;
         s.ready   = ready_map[7:0];
         s.ticks   = tick_count;
         s.created = task_count;
         status_q.push_back(s);
      endfunction

      task report_error(string msg);
         if (errors < 40) $display("ERROR: %s", msg);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_error($sformatf("word %0d %s got 0x%0h want 0x%0h",
                                   checked, name, got, want));
      endtask

      task check_status(status_type got);
         status_type want;
         if (status_q.size() == 0) begin
            report_error("status word with nothing outstanding");
            return;
         end
         want = status_q.pop_front();
         compare_field("current_priority", got.cur_pri, want.cur_pri);
         compare_field("task_active", got.active, want.active);
         compare_field("switch_requested", got.sw, want.sw);
         compare_field("ready_levels", got.ready, want.ready);
         compare_field("ticks_elapsed", got.ticks, want.ticks);
         compare_field("tasks_created", got.created, want.created);
         checked++;
      endtask

      task finish_check();
         if (status_q.size() != 0)
            report_error($sformatf("%0d status words never arrived", status_q.size()));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [1:0]        req_opcode = '0;
   logic [7:0]        req_priority_req = '0;
   logic [DLY_W-1:0]  req_delay_ticks = '0;
   logic              busy;
   logic              rsp_valid;
   logic [2:0]        rsp_current_priority;
   logic              rsp_task_active;
   logic              rsp_switch_requested;
   logic [7:0]        rsp_ready_levels;
   logic [31:0]       rsp_ticks_elapsed;
   logic [3:0]        rsp_tasks_created;

   sched_scoreboard sb = new();

   priority_bitmap_task_scheduler_top uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_priority_req     (req_priority_req),
      .req_delay_ticks      (req_delay_ticks),
      .rsp_valid            (rsp_valid),
      .rsp_current_priority (rsp_current_priority),
      .rsp_task_active      (rsp_task_active),
      .rsp_switch_requested (rsp_switch_requested),
      .rsp_ready_levels     (rsp_ready_levels),
      .rsp_ticks_elapsed    (rsp_ticks_elapsed),
      .rsp_tasks_created    (rsp_tasks_created)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_word(opcode_type'(req_opcode), req_priority_req, req_delay_ticks);
      if (!reset && rsp_valid)
         sb.check_status(status_type'{rsp_current_priority, rsp_task_active,
                                      rsp_switch_requested, rsp_ready_levels,
                                      rsp_ticks_elapsed, rsp_tasks_created});
   end

   task automatic issue(opcode_type op, logic [7:0] pri, logic [DLY_W-1:0] dly);
      start            <= 1'b1;
      req_opcode       <= op;
      req_priority_req <= pri;
      req_delay_ticks  <= dly;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic random_word();
      int               r;
      opcode_type       op;
      logic [7:0]       pri;
      logic [DLY_W-1:0] dly;
      r  = $urandom_range(0, 99);
      op = (r < 20) ? OP_CREATE : (r < 45) ? OP_DELAY : (r < 85) ? OP_TICK : OP_SWITCH;
      pri = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, NUM_LEVELS - 1))
                                        : 8'($urandom);
      case ($urandom_range(0, 9))
         0:       dly = $urandom;
         1:       dly = '1;
         default: dly = $urandom_range(0, 6);
      endcase
      issue(op, pri, dly);
   endtask

   initial begin
      int sent;
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty scheduler: delay, tick and switch with nothing to act on
      issue(OP_DELAY, 8'd0, 32'd5);
      issue(OP_TICK, 8'd0, 32'd0);
      issue(OP_SWITCH, 8'd0, 32'd0);
      // creates: lowest, clamped, re-create of a present slot, middle, clamped re-create
      issue(OP_CREATE, 8'd0, 32'd0);
      issue(OP_CREATE, 8'hFF, 32'd0);
      issue(OP_CREATE, 8'(NUM_LEVELS - 1), 32'd0);
      issue(OP_CREATE, 8'd3, 32'd0);
      issue(OP_CREATE, 8'(NUM_LEVELS), 32'hFFFF_FFFF);
      // zero delay wakes on the next tick
      issue(OP_DELAY, 8'd0, 32'd0);
      issue(OP_TICK, 8'd0, 32'd0);
      // put everything to sleep, then switch with nothing ready
      issue(OP_DELAY, 8'hFF, 32'd2);
      issue(OP_DELAY, 8'h00, 32'hFFFF_FFFF);
      issue(OP_DELAY, 8'h55, 32'd1);
      issue(OP_SWITCH, 8'hAA, 32'h0);
      issue(OP_TICK, 8'd0, 32'd0);
      issue(OP_TICK, 8'd0, 32'd0);
      issue(OP_TICK, 8'd0, 32'd0);
      // fill remaining slots, task count saturates
      for (int i = 1; i < NUM_LEVELS - 1; i++)
         if (i != 3) issue(OP_CREATE, 8'(i), $urandom);
      issue(OP_DELAY, 8'd0, 32'h5A5A_5A5A);
      issue(OP_DELAY, 8'd0, 32'hA5A5_A5A5);
      issue(OP_SWITCH, 8'd0, 32'd0);

      sent = 0;
      while (sent < 1050) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            random_word();
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
      end
      pause(1);

      for (int w = 0; w < 4000 && sb.status_q.size() != 0; w++) @(posedge clock);
      repeat (3 * NUM_LEVELS + 4) @(posedge clock);
      sb.finish_check();
      $display("Words: %0d create, %0d delay, %0d tick, %0d switch",
               sb.op_count[OP_CREATE], sb.op_count[OP_DELAY],
               sb.op_count[OP_TICK], sb.op_count[OP_SWITCH]);
      $display("Status words checked: %0d, ticks that woke a task: %0d, errors: %0d",
               sb.checked, sb.wakeups, sb.errors);
      if (sb.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout waiting on the scheduler");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
